/* rtl/minmax_pkg.sv */
package minmax_pkg;

	typedef enum logic [1:0] {
		CMD_INSERT     = 2'd0,
		CMD_REMOVE_MIN = 2'd1,
		CMD_REMOVE_MAX = 2'd2,
		CMD_CLEAR      = 2'd3
	} cmd_t;

	// datapath micro-operations issued by the controller
	typedef enum logic [4:0] {
		DP_NOP,
		DP_LOAD,
		DP_REJ,
		DP_CLR,
		DP_INS_WR,
		DP_RD_PAR,
		DP_UP_PAR,
		DP_RD_GP,
		DP_UP_GP,
		DP_WR_CUR,
		DP_MX_INIT,
		DP_MX_RD,
		DP_MX_CMP,
		DP_RM_START,
		DP_RM_LOAD,
		DP_DN_INIT,
		DP_DN_RD,
		DP_DN_CMP,
		DP_DN_SKIP,
		DP_DN_SWAP,
		DP_DN_PFIX,
		DP_OUT
	} dp_op_t;

	typedef struct packed {
		cmd_t cmd;
		logic full;
		logic empty;
		logic pos_zero;
		logic pos_ge3;
		logic g_better;
		logic cand_ok;
		logic k_done;
		logic found;
		logic down_better;
		logic grand;
		logic mx_ok;
	} dp_stat_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_UP_CHK,
		ST_UP_PAR,
		ST_GP_CHK,
		ST_UP_GP,
		ST_FIN,
		ST_MX_INIT,
		ST_MX_RD,
		ST_MX_CMP,
		ST_RM_LOAD,
		ST_DN_INIT,
		ST_DN_RD,
		ST_DN_CMP,
		ST_DN_DEC,
		ST_DN_PRD,
		ST_DN_PFIX,
		ST_OUT
	} state_t;

endpackage

/* rtl/minmax_dp.sv */
module minmax_dp #(
	parameter int CAPACITY   = 1024,
	parameter int VALUE_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  minmax_pkg::dp_op_t  op,
	input  minmax_pkg::cmd_t    in_cmd,
	input  logic [31:0]         in_value,
	output minmax_pkg::dp_stat_t stat,
	output logic [10:0]         count,
	output logic [31:0]         min_value,
	output logic [31:0]         max_value,
	output logic                is_empty,
	output logic                rejected
);
	import minmax_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = AW + 3;
	localparam int VB = VALUE_BITS;

	logic [VB-1:0] mem [CAPACITY];
	logic [VB-1:0] rdata_q;

	cmd_t          cmd_q;
	logic [VB-1:0] value_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] pos_q;
	logic [VB-1:0] cur_q;
	logic          minlvl_q;
	logic [AW-1:0] best_q;
	logic [VB-1:0] bval_q;
	logic          grand_q;
	logic          found_q;
	logic [2:0]    k_q;
	logic [1:0]    mk_q;
	logic [1:0]    mpos_q;
	logic [VB-1:0] mval_q;
	logic [VB-1:0] minv_q;
	logic          rej_q;

	logic [10:0]   count_q;
	logic [31:0]   min_q;
	logic [31:0]   max_q;
	logic          empty_q;
	logic          rejout_q;

	logic [AW-1:0] par_w;
	logic [AW-1:0] gp_w;
	logic [IW-1:0] p2, p4, cand_idx;
	logic          up_better, g_better, down_better, parsw, cand_ok;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [VB-1:0] wdata;
	logic [VB+31:0] val_x;
	logic [VB+31:0] mn_x, mx_x;
	logic [CW+10:0] cnt_x;
	logic [AW-1:0] tgt_pos;

	function automatic logic lt(input logic [VB-1:0] a, input logic [VB-1:0] b);
		return $signed(a) < $signed(b);
	endfunction

	function automatic logic better(input logic ml, input logic [VB-1:0] a,
			input logic [VB-1:0] b);
		return ml ? lt(a, b) : lt(b, a);
	endfunction

	// level parity of a heap position from the top set bit of pos+1
	function automatic logic lvl_min(input logic [AW-1:0] p);
		logic [AW:0] p1;
		logic        r;
		p1 = (AW+1)'(p) + (AW+1)'(1);
		r  = 1'b0;
		for (int i = 0; i <= AW; i++) begin
			if (p1[i]) r = (i % 2 == 0);
		end
		return r;
	endfunction

	assign val_x = {{VB{in_value[31]}}, in_value};
	assign par_w = (pos_q - AW'(1)) >> 1;
	assign gp_w  = (par_w - AW'(1)) >> 1;
	assign p2    = IW'({pos_q, 1'b0});
	assign p4    = IW'({pos_q, 2'b00});

	always_comb begin
		case (k_q)
			3'd0:    cand_idx = p2 + IW'(1);
			3'd1:    cand_idx = p4 + IW'(3);
			3'd2:    cand_idx = p4 + IW'(4);
			3'd3:    cand_idx = p2 + IW'(2);
			3'd4:    cand_idx = p4 + IW'(5);
			default: cand_idx = p4 + IW'(6);
		endcase
	end

	assign cand_ok     = cand_idx < IW'(cnt_q);
	assign up_better   = better(!minlvl_q, cur_q, rdata_q);
	assign g_better    = better(minlvl_q, cur_q, rdata_q);
	assign down_better = better(minlvl_q, bval_q, cur_q);
	assign parsw       = better(minlvl_q, rdata_q, cur_q);
	assign tgt_pos     = (cmd_q == CMD_REMOVE_MIN) ? '0 : AW'(mpos_q);

	assign stat.cmd         = cmd_q;
	assign stat.full        = cnt_q == CW'(CAPACITY);
	assign stat.empty       = cnt_q == '0;
	assign stat.pos_zero    = pos_q == '0;
	assign stat.pos_ge3     = pos_q >= AW'(3);
	assign stat.g_better    = g_better;
	assign stat.cand_ok     = cand_ok;
	assign stat.k_done      = k_q == 3'd6;
	assign stat.found       = found_q;
	assign stat.down_better = down_better;
	assign stat.grand       = grand_q;
	assign stat.mx_ok       = (mk_q != 2'd3) && (CW'(mk_q) < cnt_q);

	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = cur_q;
		raddr = '0;
		unique case (op)
			DP_INS_WR: begin
				we    = 1'b1;
				waddr = AW'(cnt_q);
				wdata = value_q;
			end
			DP_UP_PAR: begin
				we    = up_better;
				wdata = rdata_q;
			end
			DP_UP_GP: begin
				we    = 1'b1;
				wdata = rdata_q;
			end
			DP_WR_CUR: we = 1'b1;
			DP_DN_SWAP: begin
				we    = 1'b1;
				wdata = bval_q;
			end
			DP_DN_PFIX: begin
				we    = parsw;
				waddr = par_w;
			end
			DP_RD_PAR:   raddr = par_w;
			DP_RD_GP:    raddr = gp_w;
			DP_MX_RD:    raddr = AW'(mk_q);
			DP_RM_START: raddr = AW'(cnt_q - CW'(1));
			DP_DN_RD:    raddr = cand_idx[AW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			rej_q   <= 1'b0;
			found_q <= 1'b0;
			k_q     <= '0;
			mk_q    <= '0;
		end else begin
			case (op)
				DP_LOAD:     rej_q <= 1'b0;
				DP_REJ:      rej_q <= 1'b1;
				DP_CLR:      cnt_q <= '0;
				DP_INS_WR:   cnt_q <= cnt_q + CW'(1);
				DP_RM_START: cnt_q <= cnt_q - CW'(1);
				DP_MX_INIT:  mk_q <= '0;
				DP_MX_CMP:   mk_q <= mk_q + 2'd1;
				DP_DN_INIT: begin
					k_q     <= '0;
					found_q <= 1'b0;
				end
				DP_DN_SKIP:  k_q <= k_q + 3'd1;
				DP_DN_CMP: begin
					k_q <= k_q + 3'd1;
					if (!found_q || better(minlvl_q, rdata_q, bval_q)) found_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (op)
			DP_LOAD: begin
				cmd_q   <= in_cmd;
				value_q <= val_x[VB-1:0];
			end
			DP_INS_WR: begin
				cur_q    <= value_q;
				pos_q    <= AW'(cnt_q);
				minlvl_q <= lvl_min(AW'(cnt_q));
			end
			DP_UP_PAR: begin
				if (up_better) begin
					pos_q    <= par_w;
					minlvl_q <= !minlvl_q;
				end
			end
			DP_UP_GP:    pos_q <= gp_w;
			DP_MX_CMP: begin
				if (mk_q == 2'd0) begin
					minv_q <= rdata_q;
					mval_q <= rdata_q;
					mpos_q <= 2'd0;
				end else if (lt(mval_q, rdata_q)) begin
					mval_q <= rdata_q;
					mpos_q <= mk_q;
				end
			end
			DP_RM_START: pos_q <= tgt_pos;
			DP_RM_LOAD: begin
				cur_q    <= rdata_q;
				minlvl_q <= lvl_min(pos_q);
			end
			DP_DN_CMP: begin
				if (!found_q || better(minlvl_q, rdata_q, bval_q)) begin
					best_q  <= cand_idx[AW-1:0];
					bval_q  <= rdata_q;
					grand_q <= (k_q != 3'd0) && (k_q != 3'd3);
				end
			end
			DP_DN_SWAP:  pos_q <= best_q;
			DP_DN_PFIX:  if (parsw) cur_q <= rdata_q;
			DP_OUT: begin
				count_q  <= cnt_x[10:0];
				min_q    <= (cnt_q == '0) ? 32'd0 : mn_x[31:0];
				max_q    <= (cnt_q == '0) ? 32'd0 : mx_x[31:0];
				empty_q  <= cnt_q == '0;
				rejout_q <= rej_q;
			end
			default: ;
		endcase
	end

	assign cnt_x = {11'd0, cnt_q};
	assign mn_x  = {32'd0, minv_q};
	assign mx_x  = {32'd0, mval_q};

	assign count     = count_q;
	assign min_value = min_q;
	assign max_value = max_q;
	assign is_empty  = empty_q;
	assign rejected  = rejout_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY)) else $error("entry count above capacity");
	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		(op == DP_INS_WR) |-> !stat.full) else $error("insert into full heap");
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(we && op != DP_INS_WR) |-> (CW'(waddr) <= cnt_q))
		else $error("write beyond held entries");
	a_gp_swap: assert property (@(posedge clk) disable iff (!arst_n)
		(op == DP_UP_GP) |-> g_better) else $error("grandparent move without order fault");
endmodule

/* rtl/minmax_ctrl.sv */
module minmax_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  minmax_pkg::dp_stat_t stat,
	output minmax_pkg::dp_op_t   op
);
	import minmax_pkg::*;

	state_t state_q, state_d;
	logic   rmx_q;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_DISPATCH;
			ST_DISPATCH: begin
				unique case (stat.cmd)
					CMD_INSERT:     state_d = stat.full ? ST_MX_INIT : ST_UP_CHK;
					CMD_REMOVE_MIN: state_d = stat.empty ? ST_MX_INIT : ST_RM_LOAD;
					CMD_REMOVE_MAX: state_d = ST_MX_INIT;
					default:        state_d = ST_MX_INIT;
				endcase
			end
			ST_UP_CHK:   state_d = stat.pos_zero ? ST_FIN : ST_UP_PAR;
			ST_UP_PAR:   state_d = ST_GP_CHK;
			ST_GP_CHK:   state_d = stat.pos_ge3 ? ST_UP_GP : ST_FIN;
			ST_UP_GP:    state_d = stat.g_better ? ST_GP_CHK : ST_FIN;
			ST_FIN:      state_d = ST_MX_INIT;
			ST_MX_INIT:  state_d = ST_MX_RD;
			ST_MX_RD: begin
				if (stat.mx_ok) state_d = ST_MX_CMP;
				else if (rmx_q) state_d = ST_RM_LOAD;
				else state_d = ST_OUT;
			end
			ST_MX_CMP:   state_d = ST_MX_RD;
			ST_RM_LOAD:  state_d = ST_DN_INIT;
			ST_DN_INIT:  state_d = ST_DN_RD;
			ST_DN_RD: begin
				if (stat.k_done) state_d = ST_DN_DEC;
				else if (stat.cand_ok) state_d = ST_DN_CMP;
			end
			ST_DN_CMP:   state_d = ST_DN_RD;
			ST_DN_DEC: begin
				if (stat.found && stat.down_better)
					state_d = stat.grand ? ST_DN_PRD : ST_FIN;
				else
					state_d = ST_FIN;
			end
			ST_DN_PRD:   state_d = ST_DN_PFIX;
			ST_DN_PFIX:  state_d = ST_DN_INIT;
			ST_OUT:      if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		op       = DP_NOP;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) op = DP_LOAD;
			end
			ST_DISPATCH: begin
				unique case (stat.cmd)
					CMD_INSERT:     op = stat.full ? DP_REJ : DP_INS_WR;
					CMD_REMOVE_MIN: op = stat.empty ? DP_REJ : DP_RM_START;
					CMD_REMOVE_MAX: op = stat.empty ? DP_REJ : DP_NOP;
					default:        op = DP_CLR;
				endcase
			end
			ST_UP_CHK:   if (!stat.pos_zero) op = DP_RD_PAR;
			ST_UP_PAR:   op = DP_UP_PAR;
			ST_GP_CHK:   if (stat.pos_ge3) op = DP_RD_GP;
			ST_UP_GP:    if (stat.g_better) op = DP_UP_GP;
			ST_FIN:      op = DP_WR_CUR;
			ST_MX_INIT:  op = DP_MX_INIT;
			ST_MX_RD: begin
				if (stat.mx_ok) op = DP_MX_RD;
				else if (rmx_q) op = DP_RM_START;
			end
			ST_MX_CMP:   op = DP_MX_CMP;
			ST_RM_LOAD:  op = DP_RM_LOAD;
			ST_DN_INIT:  op = DP_DN_INIT;
			ST_DN_RD: begin
				if (!stat.k_done) op = stat.cand_ok ? DP_DN_RD : DP_DN_SKIP;
			end
			ST_DN_CMP:   op = DP_DN_CMP;
			ST_DN_DEC:   if (stat.found && stat.down_better) op = DP_DN_SWAP;
			ST_DN_PRD:   op = DP_RD_PAR;
			ST_DN_PFIX:  op = DP_DN_PFIX;
			ST_OUT:      if (!out_valid_q || out_ready) op = DP_OUT;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rmx_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DISPATCH)
				rmx_q <= (stat.cmd == CMD_REMOVE_MAX) && !stat.empty;
			else if (state_q == ST_MX_RD && !stat.mx_ok)
				rmx_q <= 1'b0;
			if (op == DP_OUT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(op == DP_OUT) |=> out_valid) else $error("result not presented");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_valid_q && !out_ready) |-> (op != DP_OUT))
		else $error("result overwritten while stalled");
	a_rmx_path: assert property (@(posedge clk) disable iff (!arst_n)
		(op == DP_RM_START && state_q == ST_MX_RD) |-> (stat.cmd == CMD_REMOVE_MAX))
		else $error("max removal outside remove-max command");
endmodule

/* rtl/min_max_heap_unit.sv */
// Min-max heap double-ended priority queue; one result transfer per command transfer.
// An insert sifts the new entry up against its parent, then by grandparent moves. Removals
// refill the vacated slot from the last entry and push it down; remove-max first scans the
// root and its children for the largest entry. A push-down step compares each child and
// grandchild in range and fixes the parent after a grandchild move. Reset empties the heap.
// One command in flight; the next is accepted in the cycle after the result loads.
module min_max_heap_unit #(
	parameter int CAPACITY   = 1024,
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // cmd[1:0], value[33:2], zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata    // count[10:0], min_value[42:11],
	                                    // max_value[74:43], is_empty[75],
	                                    // rejected[76], zero pad
);
	import minmax_pkg::*;

	dp_op_t   op;
	dp_stat_t stat;
	logic [10:0] count;
	logic [31:0] min_value, max_value;
	logic        is_empty, rejected;

	// controller sequences every command as datapath micro-ops
	minmax_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.op        (op)
	);

	// heap memory, walk pointers, comparators and result register
	minmax_dp #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.in_cmd    (cmd_t'(s_axis_tdata[1:0])),
		.in_value  (s_axis_tdata[33:2]),
		.stat      (stat),
		.count     (count),
		.min_value (min_value),
		.max_value (max_value),
		.is_empty  (is_empty),
		.rejected  (rejected)
	);

	// the result register holds steady until its transfer completes
	assign m_axis_tdata = {3'd0, rejected, is_empty, max_value, min_value, count};
endmodule

/* test/min_max_heap_unit_tb.sv */
module min_max_heap_unit_tb;
	import minmax_pkg::*;

	localparam int CAP = 1024;
	localparam int WATCHDOG = 200000;

	// expected result of one command
	typedef struct {
		logic [10:0] count;
		logic [31:0] min_value;
		logic [31:0] max_value;
		logic        is_empty;
		logic        rejected;
	} heap_result_t;

	// shadow heap and the results it predicts
	class heap_scoreboard;
		logic signed [31:0] heap[CAP];
		int unsigned n;
		heap_result_t pending[$];
		int mismatches;

		function new();
			n = 0;
			mismatches = 0;
		endfunction

		function bit min_lvl(int unsigned pos);
			int unsigned p;
			int bits;
			p = pos + 1;
			bits = 0;
			while (p != 0) begin
				bits++;
				p >>= 1;
			end
			return bits[0];
		endfunction

		function bit better(bit mn, logic signed [31:0] a, logic signed [31:0] b);
			return mn ? (a < b) : (b < a);
		endfunction

		function void swap(int unsigned a, int unsigned b);
			logic signed [31:0] t;
			t = heap[a];
			heap[a] = heap[b];
			heap[b] = t;
		endfunction

		function void sift_down(int unsigned pos);
			bit mn, found, grand;
			int unsigned best, c, g, par;
			mn = min_lvl(pos);
			forever begin
				best = 0;
				found = 0;
				grand = 0;
				for (int k = 1; k <= 2; k++) begin
					c = 2 * pos + k;
					if (c < n) begin
						if (!found || better(mn, heap[c], heap[best])) begin
							best = c;
							grand = 0;
							found = 1;
						end
						for (int j = 1; j <= 2; j++) begin
							g = 2 * c + j;
							if (g < n && better(mn, heap[g], heap[best])) begin
								best = g;
								grand = 1;
							end
						end
					end
				end
				if (!found || !better(mn, heap[best], heap[pos])) break;
				swap(best, pos);
				if (!grand) break;
				par = (best - 1) / 2;
				if (better(mn, heap[par], heap[best])) swap(best, par);
				pos = best;
			end
		endfunction

		function void sift_up_grand(int unsigned pos, bit mn);
			int unsigned g;
			while (pos >= 3) begin
				g = (((pos - 1) / 2) - 1) / 2;
				if (!better(mn, heap[pos], heap[g])) break;
				swap(pos, g);
				pos = g;
			end
		endfunction

		function int unsigned max_pos();
			int unsigned p;
			p = 0;
			if (n > 1 && heap[p] < heap[1]) p = 1;
			if (n > 2 && heap[p] < heap[2]) p = 2;
			return p;
		endfunction

		// note an accepted command and queue its result
		function void note_command(cmd_t cmd, logic signed [31:0] value);
			heap_result_t r;
			int unsigned pos, par, at;
			bit mn;
			r.rejected = 0;
			case (cmd)
				CMD_INSERT: begin
					if (n >= CAP) r.rejected = 1;
					else begin
						pos = n;
						heap[n] = value;
						n++;
						if (pos != 0) begin
							par = (pos - 1) / 2;
							mn = min_lvl(pos);
							if (better(!mn, heap[pos], heap[par])) begin
								swap(pos, par);
								sift_up_grand(par, !mn);
							end else sift_up_grand(pos, mn);
						end
					end
				end
				CMD_REMOVE_MIN, CMD_REMOVE_MAX: begin
					if (n == 0) r.rejected = 1;
					else begin
						at = (cmd == CMD_REMOVE_MIN) ? 0 : max_pos();
						n--;
						heap[at] = heap[n];
						sift_down(at);
					end
				end
				default: n = 0;
			endcase
			r.count = n[10:0];
			r.is_empty = (n == 0);
			r.min_value = (n == 0) ? 32'd0 : heap[0];
			r.max_value = (n == 0) ? 32'd0 : heap[max_pos()];
			pending.push_back(r);
		endfunction

		function void check_result(logic [79:0] d);
			heap_result_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", d);
				return;
			end
			e = pending.pop_front();
			if (d[10:0] !== e.count || d[42:11] !== e.min_value ||
			    d[74:43] !== e.max_value || d[75] !== e.is_empty ||
			    d[76] !== e.rejected || d[79:77] !== 3'd0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp cnt %0d min %0d max %0d emp %b rej %b, got %h",
						e.count, $signed(e.min_value), $signed(e.max_value),
						e.is_empty, e.rejected, d);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready;
	logic [79:0] m_axis_tdata;

	heap_scoreboard sb;
	bit calm;          // no idling in the closing stretch
	int quiet_cycles;

	min_max_heap_unit DUT (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// result side: random backpressure bursts, check each transfer
	initial begin
		int hold;
		m_axis_tready = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
			if (!calm && hold > 0) begin
				hold--;
				m_axis_tready <= 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(0, 7);
				m_axis_tready <= 0;
			end else m_axis_tready <= 1;
		end
	end

	// watchdog on cycles with no transfer on either side
	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else if (++quiet_cycles >= WATCHDOG) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// one command transfer, optionally preceded by an idle burst
	task automatic send_cmd(cmd_t cmd, logic signed [31:0] value);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {6'd0, value, cmd};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_command(cmd, value);
	endtask

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 15) - 8;   // many ties
			1: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_fffc}
				+ $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	function automatic cmd_t pick_cmd(int fill_bias);
		int r;
		r = $urandom_range(0, 99);
		if (r < fill_bias) return CMD_INSERT;
		if (r < 96) return $urandom_range(0, 1) ? CMD_REMOVE_MIN : CMD_REMOVE_MAX;
		return CMD_CLEAR;
	endfunction

	initial begin
		sb = new();
		calm = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: removals on empty, extremes, ties, clear
		send_cmd(CMD_REMOVE_MIN, 0);
		send_cmd(CMD_REMOVE_MAX, 0);
		send_cmd(CMD_INSERT, 32'sh7fff_ffff);
		send_cmd(CMD_INSERT, 32'sh8000_0000);
		send_cmd(CMD_INSERT, 0);
		send_cmd(CMD_INSERT, -1);
		send_cmd(CMD_INSERT, 5);
		send_cmd(CMD_INSERT, 5);
		send_cmd(CMD_INSERT, 5);
		send_cmd(CMD_REMOVE_MAX, 0);
		send_cmd(CMD_REMOVE_MIN, 0);
		send_cmd(CMD_REMOVE_MAX, 0);
		send_cmd(CMD_CLEAR, 0);
		send_cmd(CMD_CLEAR, 0);
		send_cmd(CMD_INSERT, 32'sh5555_5555);
		send_cmd(CMD_INSERT, 32'shaaaa_aaaa);
		send_cmd(CMD_REMOVE_MAX, 0);
		send_cmd(CMD_REMOVE_MAX, 0);
		send_cmd(CMD_REMOVE_MIN, 0);

		// random mix with shifting fill pressure
		for (int i = 0; i < 600; i++)
			send_cmd(pick_cmd(i < 300 ? 70 : 45), rand_value());

		// grow a deep heap, shrink it, then drain past empty
		calm = 1;
		send_cmd(CMD_CLEAR, 0);
		for (int i = 0; i < 200; i++) send_cmd(CMD_INSERT, rand_value());
		for (int i = 0; i < 60; i++) send_cmd(pick_cmd(20), 0);
		send_cmd(CMD_CLEAR, 0);
		for (int i = 0; i < 6; i++) send_cmd(CMD_INSERT, rand_value());
		for (int i = 0; i < 8; i++) send_cmd(pick_cmd(0), 0);
		s_axis_tvalid <= 0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.mismatches == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

/* sim.f */
rtl/minmax_pkg.sv
rtl/minmax_dp.sv
rtl/minmax_ctrl.sv
rtl/min_max_heap_unit.sv
test/min_max_heap_unit_tb.sv
